### sv/v4a_pkg.sv
// Shared types, constants and helpers for the four-component fixed-point vector ALU.
package v4a_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SQ_STAGES  = 32;               // one root bit per stage
  localparam int QW         = FRAC_BITS + 1;    // normalized magnitude is at most 1.0
  localparam int DIV_STAGES = QW;               // one quotient bit per stage

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_SCALE     = 3'd2,
    OP_NORM      = 3'd3,
    OP_NORMALIZE = 3'd4,
    OP_EQ        = 3'd5
  } op_t;

  // Per-item context that rides alongside the long arithmetic.
  typedef struct packed {
    logic [2:0]       op;
    logic [3:0]       neg;   // sign of each A component
    logic [3:0][31:0] mag;   // |A| per component
    logic [3:0][31:0] res;   // result vector for add/sub/scale, else zero
    logic             eq;
    logic             ovf;
    logic             big;   // sum of squares reached 2^64
  } ctx_t;

  // {overflow, saturated 32-bit value}
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### sv/v4a_if.sv
// Valid/ready channel interfaces for operand and result beats.
interface v4a_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [31:0] a_x, a_y, a_z, a_t;
  logic signed [31:0] b_x, b_y, b_z, b_t;
  logic signed [31:0] scalar;

  modport source (output valid, opcode, a_x, a_y, a_z, a_t, b_x, b_y, b_z, b_t, scalar,
                  input ready);
  modport sink   (input valid, opcode, a_x, a_y, a_z, a_t, b_x, b_y, b_z, b_t, scalar,
                  output ready);
endinterface

interface v4a_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] r_x, r_y, r_z, r_t;
  logic [32:0] length;
  logic        is_equal;
  logic        zero_vector;
  logic        overflow;

  modport source (output valid, r_x, r_y, r_z, r_t, length, is_equal, zero_vector, overflow,
                  input ready);
  modport sink   (input valid, r_x, r_y, r_z, r_t, length, is_equal, zero_vector, overflow,
                  output ready);
endinterface

### sv/vec4_fixed_point_alu.sv
// Top level of the four-component signed fixed-point vector ALU.
//
// Usage:
//   in_ch carries one operation per beat: opcode, vectors A and B, scalar,
//   all signed Q(32-FRAC_BITS).FRAC_BITS. out_ch returns exactly one result
//   beat per input beat, in order: result vector, length, is_equal,
//   zero_vector, overflow. Unused fields come back as zero.
// Throughput: one beat per cycle, every opcode, except during a stall
//   (see Stall below); all work is pipelined. The square root has 32 root
//   stages and the normalize divider has FRAC_BITS+1 quotient stages.
// Stages: input reg -> multiply (square or scale), add/sub -> scale rounding/
//   saturation and pairwise sums -> final sum -> sqrt -> divide -> output reg.
// Stall: when out_ch.ready is low and a result is held, the pipeline keeps
//   moving as long as its last stage is empty; once a beat waits there,
//   every stage freezes and in_ch.ready drops. Nothing is dropped or repeated.
// Reset: rst_n (synchronous, active low) clears all stage valid bits and
//   the output valid; data registers are not reset.
module vec4_fixed_point_alu import v4a_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  v4a_in_if.sink         in_ch,
  v4a_out_if.source      out_ch
);

  // ---------------- handshake / global advance ----------------
  logic out_v_r;
  logic out_ld;        // output register may take a new beat
  logic en;            // all pipeline stages advance
  logic v_last;

  assign out_ld      = !out_v_r || out_ch.ready;
  assign en          = out_ld || !v_last;
  assign in_ch.ready = en;

  // ---------------- stage 1: input register ----------------
  logic              v1_r;
  logic [2:0]        op1_r;
  logic [3:0][31:0]  a1_r, b1_r;
  logic [31:0]       s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_ch.opcode;
      a1_r  <= {in_ch.a_t, in_ch.a_z, in_ch.a_y, in_ch.a_x};
      b1_r  <= {in_ch.b_t, in_ch.b_z, in_ch.b_y, in_ch.b_x};
      s1_r  <= in_ch.scalar;
    end
  end

  // ---------------- stage 2: multiply, add/sub, compare ----------------
  // One signed 32x32 multiplier per lane: A*scalar for scale, A*A otherwise.
  ctx_t                    ctx2_nxt, ctx2_r;
  logic signed [3:0][63:0] p2_nxt, p2_r;
  logic                    v2_r;

  always_comb begin
    logic signed [31:0] ai, mi;
    logic signed [32:0] s33;
    logic [32:0]        sat;
    ctx2_nxt     = '0;
    ctx2_nxt.op  = op1_r;
    ctx2_nxt.eq  = (op1_r == OP_EQ) && (a1_r == b1_r);
    for (int l = 0; l < 4; l++) begin
      ai              = a1_r[l];
      mi              = (op1_r == OP_SCALE) ? s1_r : a1_r[l];
      p2_nxt[l]       = ai * mi;
      ctx2_nxt.neg[l] = ai[31];
      ctx2_nxt.mag[l] = ai[31] ? (32'd0 - a1_r[l]) : a1_r[l];
      if (op1_r == OP_SUB) begin
        s33 = {ai[31], ai} - {b1_r[l][31], b1_r[l]};
      end else begin
        s33 = {ai[31], ai} + {b1_r[l][31], b1_r[l]};
      end
      sat = sat32({{32{s33[32]}}, s33});
      if (op1_r == OP_ADD || op1_r == OP_SUB) begin
        ctx2_nxt.res[l] = sat[31:0];
        ctx2_nxt.ovf    = ctx2_nxt.ovf | sat[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx2_nxt;
      p2_r   <= p2_nxt;
    end
  end

  // ---------------- stage 3: scale rounding, pairwise square sums ----------------
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  ctx_t        ctx3_nxt, ctx3_r;
  logic [63:0] s01_r, s23_r;
  logic        v3_r;

  always_comb begin
    logic signed [63:0] pr;
    logic signed [63:0] sh;
    logic [32:0]        sat;
    ctx3_nxt = ctx2_r;
    for (int l = 0; l < 4; l++) begin
      pr  = p2_r[l] + RND;
      sh  = pr >>> FRAC_BITS;     // floor shift
      sat = sat32({sh[63], sh});
      if (ctx2_r.op == OP_SCALE) begin
        ctx3_nxt.res[l] = sat[31:0];
        ctx3_nxt.ovf    = ctx3_nxt.ovf | sat[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  // squares are at most 2^62, so a pair sum fits 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      ctx3_r <= ctx3_nxt;
      s01_r  <= p2_r[0] + p2_r[1];
      s23_r  <= p2_r[2] + p2_r[3];
    end
  end

  // ---------------- stage 4: final sum of squares ----------------
  ctx_t        ctx4_nxt, ctx4_r;
  logic [64:0] sum4;
  logic [63:0] n4_r;
  logic        v4_r;

  always_comb begin
    sum4         = {1'b0, s01_r} + {1'b0, s23_r};
    ctx4_nxt     = ctx3_r;
    ctx4_nxt.big = sum4[64];   // only when every component is the most negative value
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx4_r <= ctx4_nxt;
      n4_r   <= sum4[63:0];
    end
  end

  // ---------------- square root ----------------
  logic        v5;
  logic [31:0] root5;
  ctx_t        ctx5;
  logic [32:0] len5;

  v4a_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v4_r),
    .n_in     (n4_r),
    .ctx_in   (ctx4_r),
    .v_out    (v5),
    .root_out (root5),
    .ctx_out  (ctx5)
  );

  assign len5 = ctx5.big ? {1'b1, 32'd0} : {1'b0, root5};

  // ---------------- normalize divider ----------------
  logic               v6;
  logic [32:0]        len6;
  logic [3:0][QW-1:0] q6;
  ctx_t               ctx6;

  v4a_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (v5),
    .len_in  (len5),
    .ctx_in  (ctx5),
    .v_out   (v6),
    .len_out (len6),
    .q_out   (q6),
    .ctx_out (ctx6)
  );

  assign v_last = v6;

  // ---------------- result select and output register ----------------
  logic [3:0][31:0] r_nxt, r_r;
  logic [32:0]      len_nxt, len_r;
  logic             zero_nxt, zero_r, eq_r, ovf_r;

  always_comb begin
    logic is_len, is_nrm;
    is_len   = (ctx6.op == OP_NORM) || (ctx6.op == OP_NORMALIZE);
    is_nrm   = (ctx6.op == OP_NORMALIZE);
    len_nxt  = is_len ? len6 : '0;
    zero_nxt = is_nrm && (len6 == '0);
    r_nxt    = ctx6.res;
    if (is_nrm && (len6 != '0)) begin
      for (int l = 0; l < 4; l++) begin
        r_nxt[l] = ctx6.neg[l] ? (32'd0 - 32'(q6[l])) : 32'(q6[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && v6) begin
      r_r    <= r_nxt;
      len_r  <= len_nxt;
      zero_r <= zero_nxt;
      eq_r   <= ctx6.eq;
      ovf_r  <= ctx6.ovf;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.r_x         = r_r[0];
  assign out_ch.r_y         = r_r[1];
  assign out_ch.r_z         = r_r[2];
  assign out_ch.r_t         = r_r[3];
  assign out_ch.length      = len_r;
  assign out_ch.is_equal    = eq_r;
  assign out_ch.zero_vector = zero_r;
  assign out_ch.overflow    = ovf_r;

`ifndef SYNTHESIS
  // a normalized zero vector carries no length, no overflow and no components (checks x, t)
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_vector |->
      out_ch.length == '0 && out_ch.r_x == '0 && out_ch.r_t == '0 && !out_ch.overflow)
    else $error("zero_vector beat with nonzero payload");

  // equality results never report a length or an overflow
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_equal |-> out_ch.length == '0 && !out_ch.overflow)
    else $error("is_equal beat with length or overflow");

  // with no result held the pipeline must be open for input
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output is empty");

  // a held result is only replaced after it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.length))
    else $error("held result changed");
`endif

endmodule

### sv/v4a_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module v4a_sqrt import v4a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_in,
  input  logic [63:0] n_in,
  input  ctx_t        ctx_in,
  output logic        v_out,
  output logic [31:0] root_out,
  output ctx_t        ctx_out
);

  logic        v_r    [SQ_STAGES];
  logic [63:0] n_r    [SQ_STAGES];
  logic [33:0] rem_r  [SQ_STAGES];
  logic [31:0] root_r [SQ_STAGES];
  ctx_t        ctx_r  [SQ_STAGES];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_st
    localparam int I = SQ_STAGES - 1 - j;
    logic        v_i;
    logic [63:0] n_i;
    logic [33:0] rem_i;
    logic [31:0] root_i;
    ctx_t        ctx_i;
    logic [35:0] rs, trial, diff;
    logic [33:0] rem_nxt;
    logic [31:0] root_nxt;

    if (j == 0) begin : g_first
      assign v_i    = v_in;
      assign n_i    = n_in;
      assign rem_i  = '0;
      assign root_i = '0;
      assign ctx_i  = ctx_in;
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign n_i    = n_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign ctx_i  = ctx_r[j-1];
    end

    always_comb begin
      rs    = {rem_i, n_i[2*I+1 -: 2]};
      trial = {2'b00, root_i, 2'b01};
      diff  = rs - trial;
      if (rs >= trial) begin
        rem_nxt  = diff[33:0];
        root_nxt = {root_i[30:0], 1'b1};
      end else begin
        rem_nxt  = rs[33:0];
        root_nxt = {root_i[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j]    <= n_i;
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        ctx_r[j]  <= ctx_i;
      end
    end
  end

  assign v_out    = v_r[SQ_STAGES-1];
  assign root_out = root_r[SQ_STAGES-1];
  assign ctx_out  = ctx_r[SQ_STAGES-1];

endmodule

### sv/v4a_div.sv
// Pipelined restoring divider: four lanes of (|A| << FRAC_BITS) / length.
module v4a_div import v4a_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_in,
  input  logic [32:0]         len_in,
  input  ctx_t                ctx_in,
  output logic                v_out,
  output logic [32:0]         len_out,
  output logic [3:0][QW-1:0]  q_out,
  output ctx_t                ctx_out
);

  logic                v_r   [DIV_STAGES];
  logic [32:0]         len_r [DIV_STAGES];
  logic [3:0][32:0]    rem_r [DIV_STAGES];
  logic [3:0][QW-1:0]  q_r   [DIV_STAGES];
  ctx_t                ctx_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
    logic               v_i;
    logic [32:0]        len_i;
    logic [3:0][32:0]   rem_i;
    logic [3:0][QW-1:0] q_i;
    logic [3:0]         bit_i;
    ctx_t               ctx_i;
    logic [3:0][32:0]   rem_nxt;
    logic [3:0][QW-1:0] q_nxt;

    if (j == 0) begin : g_first
      // the quotient fits QW bits, so the upper dividend bits collapse into |A| >> 1
      assign v_i   = v_in;
      assign len_i = len_in;
      assign ctx_i = ctx_in;
      assign q_i   = '0;
      for (genvar l = 0; l < 4; l++) begin : g_ln
        assign rem_i[l] = {2'b00, ctx_in.mag[l][31:1]};
        assign bit_i[l] = ctx_in.mag[l][0];
      end
    end else begin : g_next
      assign v_i   = v_r[j-1];
      assign len_i = len_r[j-1];
      assign ctx_i = ctx_r[j-1];
      assign q_i   = q_r[j-1];
      assign rem_i = rem_r[j-1];
      assign bit_i = '0;
    end

    always_comb begin
      logic [33:0] rs;
      logic [33:0] diff;
      for (int l = 0; l < 4; l++) begin
        rs   = {rem_i[l], bit_i[l]};
        diff = rs - {1'b0, len_i};
        if (rs >= {1'b0, len_i}) begin
          rem_nxt[l] = diff[32:0];
          q_nxt[l]   = {q_i[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rs[32:0];
          q_nxt[l]   = {q_i[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j] <= len_i;
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        ctx_r[j] <= ctx_i;
      end
    end
  end

  assign v_out   = v_r[DIV_STAGES-1];
  assign len_out = len_r[DIV_STAGES-1];
  assign q_out   = q_r[DIV_STAGES-1];
  assign ctx_out = ctx_r[DIV_STAGES-1];

endmodule
